// ----- design/agr_pkg.sv -----
// Package with the word types, constants and arithmetic helpers of the accumulate/resolve block.
package agr_pkg;

   localparam int CHAN_W = 16;
   localparam int SUM_W  = 26;
   localparam int FC_W   = 11;
   localparam int AVG_W  = 38;
   localparam int GAM_W  = 19;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [GAM_W-1:0] ONE_Q12 = GAM_W'(4096);

   typedef struct packed {
      logic [15:0] pixel_index;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] packed_rgba;
      logic [15:0] luminance;
   } rsp_word_type;

   typedef logic [SUM_W-1:0] sum_type;

   // Channel byte from a Q7.12 gamma value, clamped to one.
   function automatic logic [7:0] to_byte(input logic [GAM_W-1:0] g);
      logic [GAM_W-1:0] c;
      logic [GAM_W+7:0] p;
      c = (g > ONE_Q12) ? ONE_Q12 : g;
      p = {8'd0, c} * (GAM_W+8)'(255);
      return p[19:12];
   endfunction

endpackage

// ----- design/accumulate_gamma_resolve_top.sv -----
// Top level of the accumulate/resolve block: accumulation, average, root, pack.
// One pixel word is accepted per cycle while req_stall is low; its result passes
// two memory stages, a 39-stage divider, a 20-stage square root and two output
// stages. The pipeline halts as a whole while a result waits in the skid
// register, which fills when rsp_stall holds back a full output register. After
// reset a clearing pass zeroes all PIXEL_COUNT entries of the accumulator memory
// one entry per cycle, during which req_stall is high. The sums live in one
// memory with a registered read, and back-to-back updates of one pixel are
// forwarded.
module accumulate_gamma_resolve_top
   #(
      parameter int PIXEL_COUNT = 65536,
      parameter int MAX_FRAMES  = 1024
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  req_valid,
      output logic                  req_stall,
      input  agr_pkg::req_word_type req_word,
      output logic                  rsp_valid,
      input  logic                  rsp_stall,
      output agr_pkg::rsp_word_type rsp_word,
      input  logic                  csr_write,
      input  logic [agr_pkg::FC_W-1:0] csr_data
   );
   import agr_pkg::*;

   logic [FC_W-1:0] fc_ff;
   logic [FC_W-1:0] fc_eff;
   always_ff @(posedge clock) begin
      if (reset) fc_ff <= FC_W'(1);
      else if (csr_write) fc_ff <= csr_data;
   end

   always_comb begin
      fc_eff = fc_ff;
      if (fc_ff == '0) fc_eff = FC_W'(1);
      if ({21'd0, fc_eff} > 32'(MAX_FRAMES)) fc_eff = FC_W'(MAX_FRAMES);
   end

   // Output register with one skid word; the pipe halts while the skid holds a result.
   logic          pipe_stall;
   logic          o_vld_ff, sk_vld_ff;
   rsp_word_type  o_ff, sk_ff;

   assign pipe_stall = sk_vld_ff;

   logic          acc_busy;
   logic          acc_vld;
   logic [3*SUM_W-1:0] acc_sums;
   logic          div_vld;
   logic [3*AVG_W-1:0] div_avgs;
   logic [FC_W-1:0] fc_pipe;
   logic          sq_vld;
   logic [3*GAM_W-1:0] sq_gams;

   agr_accum #(.PIXEL_COUNT(PIXEL_COUNT)) u_accum (
      .clock(clock), .reset(reset),
      .in_valid(req_valid && !req_stall),
      .in_index(req_word.pixel_index),
      .in_rgb({req_word.blue_in, req_word.green_in, req_word.red_in}),
      .in_clear(fc_eff == FC_W'(1)),
      .stall(pipe_stall),
      .out_valid(acc_vld), .out_sums(acc_sums));

   // A counter that runs in step with the accumulator's clearing pass holds off input.
   logic [$clog2(PIXEL_COUNT+1):0] boot_ff;
   assign acc_busy = (boot_ff < ($clog2(PIXEL_COUNT+1)+1)'(PIXEL_COUNT));
   always_ff @(posedge clock) begin
      if (reset) boot_ff <= '0;
      else if (acc_busy) boot_ff <= boot_ff + 1'b1;
   end
   assign req_stall = pipe_stall || acc_busy;

   // User must hold frame count constant with items in flight; block does not enforce.
   always_ff @(posedge clock) begin
      if (!pipe_stall) fc_pipe <= fc_eff;
   end

   agr_div u_div (
      .clock(clock), .reset(reset),
      .in_valid(acc_vld), .in_sums(acc_sums), .in_fc(fc_pipe),
      .stall(pipe_stall),
      .out_valid(div_vld), .out_avgs(div_avgs));

   agr_sqrt u_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(div_vld), .in_avgs(div_avgs),
      .stall(pipe_stall),
      .out_valid(sq_vld), .out_gams(sq_gams));

   // Weighted sum registered, then divided by 100 via reciprocal.
   logic          w_vld_ff;
   logic [25:0]   w_sum_ff;
   logic [23:0]   w_rgb_ff;
   logic [GAM_W-1:0] gr, gg, gb;
   assign gr = sq_gams[0 +: GAM_W];
   assign gg = sq_gams[GAM_W +: GAM_W];
   assign gb = sq_gams[2*GAM_W +: GAM_W];

   always_ff @(posedge clock) begin
      if (reset) w_vld_ff <= 1'b0;
      else if (!pipe_stall) w_vld_ff <= sq_vld;
   end
   always_ff @(posedge clock) begin
      if (!pipe_stall) begin
         w_sum_ff <= 26'(27 * {7'd0, gr}) + 26'(67 * {7'd0, gg}) + 26'(6 * {7'd0, gb});
         w_rgb_ff <= {to_byte(gb), to_byte(gg), to_byte(gr)};
      end
   end

   // floor(x/100) for x < 2^26: multiply by ceil(2^33/100), shift 33.
   logic [59:0] q_prod;
   logic [26:0] q_raw;
   logic [15:0] lum;
   assign q_prod = {34'd0, w_sum_ff} * 60'd85899346;
   assign q_raw  = q_prod[59:33];
   assign lum    = (q_raw > 27'd65535) ? 16'hFFFF : q_raw[15:0];

   rsp_word_type res;
   assign res.packed_rgba = {8'hFF, w_rgb_ff};
   assign res.luminance   = lum;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff  <= 1'b0;
         sk_vld_ff <= 1'b0;
      end else begin
         if (!o_vld_ff || !rsp_stall) begin
            o_vld_ff  <= sk_vld_ff || (w_vld_ff && !pipe_stall);
            sk_vld_ff <= 1'b0;
         end else if (w_vld_ff && !pipe_stall) begin
            sk_vld_ff <= 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (!o_vld_ff || !rsp_stall) begin
         o_ff <= sk_vld_ff ? sk_ff : res;
      end
      if (!pipe_stall) sk_ff <= res;
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_word  = o_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sk_vld_ff |-> o_vld_ff) else $error("skid full with output empty");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (sk_vld_ff && !rsp_stall) |=> !sk_vld_ff) else $error("skid not drained");
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.packed_rgba[31:24] == 8'hFF) else $error("alpha wrong");
`endif

endmodule

// ----- design/agr_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, for the three channel averages.
module agr_div
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  in_valid,
      input  logic [3*agr_pkg::SUM_W-1:0] in_sums,
      input  logic [agr_pkg::FC_W-1:0] in_fc,
      input  logic                  stall,
      output logic                  out_valid,
      output logic [3*agr_pkg::AVG_W-1:0] out_avgs
   );
   import agr_pkg::*;

   localparam int NS = AVG_W;

   logic [NS:0]            vld_ff;
   logic [FC_W-1:0]        fc_ff  [NS+1];
   logic [AVG_W-1:0]       num_ff [NS+1][3];
   logic [FC_W:0]          rem_ff [NS+1][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         fc_ff[0] <= in_fc;
         for (int c = 0; c < 3; c++) begin
            num_ff[0][c] <= {in_sums[c*SUM_W +: SUM_W], 12'd0};
            rem_ff[0][c] <= '0;
         end
         for (int s = 0; s < NS; s++) begin
            fc_ff[s+1] <= fc_ff[s];
            for (int c = 0; c < 3; c++) begin
               logic [FC_W+1:0] t;
               t = {rem_ff[s][c], num_ff[s][c][AVG_W-1]};
               if (t >= {2'd0, fc_ff[s]}) begin
                  rem_ff[s+1][c] <= (FC_W+1)'(t - {2'd0, fc_ff[s]});
                  num_ff[s+1][c] <= {num_ff[s][c][AVG_W-2:0], 1'b1};
               end else begin
                  rem_ff[s+1][c] <= t[FC_W:0];
                  num_ff[s+1][c] <= {num_ff[s][c][AVG_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[NS];
   always_comb begin
      for (int c = 0; c < 3; c++) out_avgs[c*AVG_W +: AVG_W] = num_ff[NS][c];
   end

endmodule

// ----- design/agr_sqrt.sv -----
// Pipelined integer square root: one result bit per stage for three channels.
module agr_sqrt
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  in_valid,
      input  logic [3*agr_pkg::AVG_W-1:0] in_avgs,
      input  logic                  stall,
      output logic                  out_valid,
      output logic [3*agr_pkg::GAM_W-1:0] out_gams
   );
   import agr_pkg::*;

   localparam int NS = GAM_W;

   logic [NS:0]        vld_ff;
   logic [AVG_W-1:0]   rad_ff [NS+1][3];
   logic [GAM_W+1:0]   rem_ff [NS+1][3];
   logic [GAM_W-1:0]   root_ff [NS+1][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   // Digit-by-digit method: two radicand bits enter each stage.
   always_ff @(posedge clock) begin
      if (!stall) begin
         for (int c = 0; c < 3; c++) begin
            rad_ff[0][c]  <= in_avgs[c*AVG_W +: AVG_W];
            rem_ff[0][c]  <= '0;
            root_ff[0][c] <= '0;
         end
         for (int s = 0; s < NS; s++) begin
            for (int c = 0; c < 3; c++) begin
               logic [GAM_W+3:0] r;
               logic [GAM_W+3:0] t;
               r = {rem_ff[s][c], rad_ff[s][c][AVG_W-1 -: 2]};
               t = {2'd0, root_ff[s][c], 2'b01};
               rad_ff[s+1][c] <= {rad_ff[s][c][AVG_W-3:0], 2'b00};
               if (r >= t) begin
                  rem_ff[s+1][c]  <= (GAM_W+2)'(r - t);
                  root_ff[s+1][c] <= {root_ff[s][c][GAM_W-2:0], 1'b1};
               end else begin
                  rem_ff[s+1][c]  <= r[GAM_W+1:0];
                  root_ff[s+1][c] <= {root_ff[s][c][GAM_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[NS];
   always_comb begin
      for (int c = 0; c < 3; c++) out_gams[c*GAM_W +: GAM_W] = root_ff[NS][c];
   end

endmodule

// ----- design/agr_accum.sv -----
// Accumulator memory with read-modify-write and forwarding of recent writes.
module agr_accum
   #(
      parameter int PIXEL_COUNT = 65536
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  in_valid,
      input  logic [15:0]           in_index,
      input  logic [3*agr_pkg::CHAN_W-1:0] in_rgb,
      input  logic                  in_clear,
      input  logic                  stall,
      output logic                  out_valid,
      output logic [3*agr_pkg::SUM_W-1:0] out_sums
   );
   import agr_pkg::*;

   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   // Clearing pass: every entry is zeroed after reset, one per cycle.
   logic [AW:0]          clr_ff;
   logic                 clr_busy;
   assign clr_busy = (clr_ff < (AW+1)'(PIXEL_COUNT));
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (clr_busy) clr_ff <= clr_ff + 1'b1;
   end

   logic [3*SUM_W-1:0]   mem [PIXEL_COUNT];
   logic [3*SUM_W-1:0]   rd_ff;

   // Stage one: address registered with the memory read.
   logic                 s1_vld_ff, s1_ok_ff, s1_clr_ff;
   logic [AW-1:0]        s1_adr_ff;
   logic [3*CHAN_W-1:0]  s1_rgb_ff;
   // Stage two: sum registered and written back.
   logic                 s2_vld_ff, s2_ok_ff;
   logic [AW-1:0]        s2_adr_ff;
   logic [3*SUM_W-1:0]   s2_sum_ff;
   logic [3*SUM_W-1:0]   s1_sum_in;
   logic [3*SUM_W-1:0]   old_sum;
   logic                 in_ok;
   logic                 adv;

   assign adv   = !stall && !clr_busy;
   assign in_ok = ({16'd0, in_index} < 32'(PIXEL_COUNT));

   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (adv && s1_vld_ff && s1_ok_ff) begin
         mem[s1_adr_ff] <= s1_sum_in;
      end
      if (adv) rd_ff <= mem[in_index[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff  <= in_ok;
         s1_clr_ff <= in_clear;
         s1_adr_ff <= in_index[AW-1:0];
         s1_rgb_ff <= in_rgb;
         s2_ok_ff  <= s1_vld_ff && s1_ok_ff;
         s2_adr_ff <= s1_adr_ff;
         s2_sum_ff <= s1_sum_in;
      end
   end

   // The sum written during the read is newer than what the memory returned.
   logic fwd_ff;
   always_ff @(posedge clock) begin
      if (reset) fwd_ff <= 1'b0;
      else if (adv) fwd_ff <= in_valid && s1_vld_ff && s1_ok_ff && in_ok
                              && (s1_adr_ff == in_index[AW-1:0]);
   end

   assign old_sum = fwd_ff ? s2_sum_ff : rd_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [SUM_W:0] s;
         logic [SUM_W-1:0] o;
         o = (s1_ok_ff && !s1_clr_ff) ? old_sum[c*SUM_W +: SUM_W] : '0;
         s = {1'b0, o} + (SUM_W+1)'(s1_rgb_ff[c*CHAN_W +: CHAN_W]);
         s1_sum_in[c*SUM_W +: SUM_W] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
      end
   end

   assign out_valid = s2_vld_ff && !clr_busy;
   assign out_sums  = s2_sum_ff;

`ifndef SYNTH
   a_fwd_only_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_vld_ff) else $error("forwarding without an item");
   a_no_item_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !s1_vld_ff && !s2_vld_ff) else $error("item during clearing pass");
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && s2_ok_ff) |-> $past(s1_ok_ff)) else $error("write of bad index");
`endif

endmodule
